// ===== design/sssc_pkg.sv =====
// Shared types, widths and constants of the segment/sphere obstacle check.
package sssc_pkg;

  localparam int COORD_BITS      = 24;
  localparam int RADIUS_BITS     = COORD_BITS - 1;
  localparam int COUNT_BITS      = 7;
  localparam int INDEX_BITS      = 6;
  localparam int MAX_SPHERES_DEF = 64;

  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int SQ_BITS      = 2 * DIFF_BITS + 2;
  localparam int ACC_BITS     = 2 * SQ_BITS + 2;
  localparam int DIG_BITS     = 32;
  localparam int NDIG         = (SQ_BITS + DIG_BITS - 1) / DIG_BITS;
  localparam int NDIG_SMALL   = (DIFF_BITS + DIG_BITS - 1) / DIG_BITS;
  localparam int DIG_CNT_BITS = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int QDEPTH       = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    logic                   operation;
    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 start_z;
    coord_t                 end_x;
    coord_t                 end_y;
    coord_t                 end_z;
    logic [INDEX_BITS-1:0]  entry_index;
    coord_t                 center_x;
    coord_t                 center_y;
    coord_t                 center_z;
    logic [RADIUS_BITS-1:0] radius;
  } sssc_in_t;

  typedef struct packed {
    logic                  segment_clear;
    logic [INDEX_BITS-1:0] first_hit_index;
  } sssc_out_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t                  kind;
    logic [INDEX_BITS-1:0]  slot;
    coord_t                 p0x;
    coord_t                 p0y;
    coord_t                 p0z;
    coord_t                 p1x;
    coord_t                 p1y;
    coord_t                 p1z;
    logic [RADIUS_BITS-1:0] radius;
  } sssc_cmd_t;

  typedef struct packed {
    logic      valid;
    sssc_cmd_t cmd;
  } sssc_push_t;

  typedef struct packed {
    coord_t                 x;
    coord_t                 y;
    coord_t                 z;
    logic [RADIUS_BITS-1:0] r;
  } sssc_sphere_t;

endpackage

// ===== design/sssc_front.sv =====
// Front end: takes input requests, classifies them and drops out-of-range loads.
module sssc_front import sssc_pkg::*; #(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sssc_in_t   in_data,
  output sssc_push_t push,
  input  logic       q_full
);

  logic      fr_valid_r, fr_valid_nxt;
  sssc_cmd_t fr_cmd_r, fr_cmd_nxt;
  logic      accept, pushed, keep;

  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign pushed   = fr_valid_r && !q_full;
  assign keep     = in_data.operation || (32'(in_data.entry_index) < MAX_SPHERES);

  always_comb begin
    fr_cmd_nxt.kind   = kind_t'(in_data.operation);
    fr_cmd_nxt.slot   = in_data.entry_index;
    fr_cmd_nxt.radius = in_data.radius;
    fr_cmd_nxt.p1x    = in_data.end_x;
    fr_cmd_nxt.p1y    = in_data.end_y;
    fr_cmd_nxt.p1z    = in_data.end_z;
    if (in_data.operation) begin
      fr_cmd_nxt.p0x = in_data.start_x;
      fr_cmd_nxt.p0y = in_data.start_y;
      fr_cmd_nxt.p0z = in_data.start_z;
    end else begin
      fr_cmd_nxt.p0x = in_data.center_x;
      fr_cmd_nxt.p0y = in_data.center_y;
      fr_cmd_nxt.p0z = in_data.center_z;
    end
    if (accept) begin
      fr_valid_nxt = keep;
    end else if (pushed) begin
      fr_valid_nxt = 1'b0;
    end else begin
      fr_valid_nxt = fr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r <= fr_cmd_nxt;
    end
  end

  assign push.valid = pushed;
  assign push.cmd   = fr_cmd_r;

endmodule

// ===== design/sssc_queue.sv =====
// Short request queue between front and back end.
module sssc_queue import sssc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sssc_push_t push,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output sssc_cmd_t  head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  sssc_cmd_t     slots_r [QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == (PW+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push.cmd;
    end
  end

endmodule

// ===== design/sssc_back.sv =====
// Back end: sphere table, shared 32x32 multiply-accumulate and the test sequencer.
module sssc_back import sssc_pkg::*; #(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  q_empty,
  input  sssc_cmd_t             q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sssc_out_t             out_data
);

  localparam int AIW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW  = $clog2(MAX_SPHERES + 1);
  localparam int XW  = NDIG * DIG_BITS;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_QSTART = 9'b000000010,
    S_FETCH  = 9'b000000100,
    S_DIFF   = 9'b000001000,
    S_MUL    = 9'b000010000,
    S_DRAIN  = 9'b000100000,
    S_NEXT   = 9'b001000000,
    S_DECIDE = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    OP_AB0, OP_AB1, OP_AB2,
    OP_AC0, OP_AC1, OP_AC2,
    OP_DOT0, OP_DOT1, OP_DOT2,
    OP_RR,
    OP_BC0, OP_BC1, OP_BC2,
    OP_T1, OP_T2, OP_T3
  } op_t;

  function automatic logic [DIFF_BITS:0] diff_mag(coord_t p, coord_t q);
    logic [DIFF_BITS-1:0] d;
    logic                 neg;
    d   = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    neg = d[DIFF_BITS-1];
    return {neg, neg ? (~d + 1'b1) : d};
  endfunction

  sssc_sphere_t mem [MAX_SPHERES];
  sssc_sphere_t rd_r;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [COUNT_BITS-1:0]   count_r;
  logic [CW-1:0]           idx_r, idx_nxt, n_r;
  logic [DIG_CNT_BITS-1:0] i_r, i_nxt, j_r, j_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sssc_out_t               out_r, res_r, res_nxt;

  coord_t               a_r [3];
  coord_t               b_r [3];
  coord_t               c_sel [3];
  logic [DIFF_BITS-1:0] ab_mag_r [3];
  logic [DIFF_BITS-1:0] ac_mag_r [3];
  logic [DIFF_BITS-1:0] bc_mag_r [3];
  logic                 ab_neg_r [3];
  logic                 ac_neg_r [3];
  logic                 bc_neg_r [3];
  logic [SQ_BITS-1:0]   ab2_r, ac2_r, r2_r, dot_mag_r;
  logic                 dot_neg_r, dot_zero_r;

  logic [ACC_BITS-1:0]     acc_r, acc_abs, sh_val;
  logic [2*DIG_BITS-1:0]   pp_r;
  logic [DIG_CNT_BITS:0]   pp_sh_r;
  logic                    pp_neg_r, pp_v_r;

  logic [SQ_BITS-1:0]  x_op, y_op;
  logic [XW-1:0]       x_ext, y_ext;
  logic [DIG_BITS-1:0] x_dig, y_dig;
  logic                op_neg, op_big;
  logic [DIG_CNT_BITS-1:0] last_dig;
  logic                acc_clr, hit, resolve;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  assign c_sel[0] = rd_r.x;
  assign c_sel[1] = rd_r.y;
  assign c_sel[2] = rd_r.z;

  // operand select for the shared multiplier
  always_comb begin
    x_op   = '0;
    y_op   = '0;
    op_neg = 1'b0;
    op_big = 1'b0;
    case (op_r)
      OP_AB0:  begin x_op = SQ_BITS'(ab_mag_r[0]); y_op = x_op; end
      OP_AB1:  begin x_op = SQ_BITS'(ab_mag_r[1]); y_op = x_op; end
      OP_AB2:  begin x_op = SQ_BITS'(ab_mag_r[2]); y_op = x_op; end
      OP_AC0:  begin x_op = SQ_BITS'(ac_mag_r[0]); y_op = x_op; end
      OP_AC1:  begin x_op = SQ_BITS'(ac_mag_r[1]); y_op = x_op; end
      OP_AC2:  begin x_op = SQ_BITS'(ac_mag_r[2]); y_op = x_op; end
      OP_DOT0: begin
        x_op   = SQ_BITS'(ac_mag_r[0]);
        y_op   = SQ_BITS'(ab_mag_r[0]);
        op_neg = ac_neg_r[0] ^ ab_neg_r[0];
      end
      OP_DOT1: begin
        x_op   = SQ_BITS'(ac_mag_r[1]);
        y_op   = SQ_BITS'(ab_mag_r[1]);
        op_neg = ac_neg_r[1] ^ ab_neg_r[1];
      end
      OP_DOT2: begin
        x_op   = SQ_BITS'(ac_mag_r[2]);
        y_op   = SQ_BITS'(ab_mag_r[2]);
        op_neg = ac_neg_r[2] ^ ab_neg_r[2];
      end
      OP_RR:   begin x_op = SQ_BITS'(rd_r.r); y_op = x_op; end
      OP_BC0:  begin x_op = SQ_BITS'(bc_mag_r[0]); y_op = x_op; end
      OP_BC1:  begin x_op = SQ_BITS'(bc_mag_r[1]); y_op = x_op; end
      OP_BC2:  begin x_op = SQ_BITS'(bc_mag_r[2]); y_op = x_op; end
      OP_T1:   begin x_op = dot_mag_r; y_op = dot_mag_r; op_big = 1'b1; end
      OP_T2:   begin x_op = r2_r; y_op = ab2_r; op_big = 1'b1; end
      OP_T3:   begin x_op = ac2_r; y_op = ab2_r; op_big = 1'b1; op_neg = 1'b1; end
      default: begin x_op = '0; y_op = '0; end
    endcase
  end

  assign x_ext    = XW'(x_op);
  assign y_ext    = XW'(y_op);
  assign x_dig    = x_ext[i_r*DIG_BITS +: DIG_BITS];
  assign y_dig    = y_ext[j_r*DIG_BITS +: DIG_BITS];
  assign last_dig = op_big ? DIG_CNT_BITS'(NDIG - 1) : DIG_CNT_BITS'(NDIG_SMALL - 1);
  assign sh_val   = ACC_BITS'(pp_r) << (DIG_BITS * pp_sh_r);
  assign acc_abs  = acc_r[ACC_BITS-1] ? (~acc_r + 1'b1) : acc_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    res_nxt   = res_r;
    acc_clr   = 1'b0;
    hit       = 1'b0;
    resolve   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty && q_head.kind == KIND_QUERY) begin
          state_nxt = S_QSTART;
        end
      end
      S_QSTART: begin
        acc_clr   = 1'b1;
        op_nxt    = OP_AB0;
        state_nxt = S_MUL;
      end
      S_FETCH: state_nxt = S_DIFF;
      S_DIFF: begin
        op_nxt    = OP_AC0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (j_r == last_dig) begin
          j_nxt = '0;
          if (i_r == last_dig) begin
            i_nxt     = '0;
            state_nxt = S_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: state_nxt = S_NEXT;
      S_NEXT: begin
        state_nxt = S_MUL;
        op_nxt    = op_t'(op_r + 1'b1);
        case (op_r)
          OP_AB2: begin
            acc_clr = 1'b1;
            idx_nxt = '0;
            if (n_r == '0) begin
              res_nxt   = '{segment_clear: 1'b1, first_hit_index: '0};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          OP_AC2, OP_DOT2: acc_clr = 1'b1;
          OP_RR: begin
            acc_clr   = 1'b1;
            state_nxt = S_DECIDE;
          end
          OP_BC2: begin
            acc_clr = 1'b1;
            hit     = r2_r >= acc_r[SQ_BITS-1:0];
            resolve = 1'b1;
          end
          OP_T3: begin
            acc_clr = 1'b1;
            hit     = !acc_r[ACC_BITS-1];
            resolve = 1'b1;
          end
          default: ;
        endcase
      end
      S_DECIDE: begin
        state_nxt = S_MUL;
        if (dot_neg_r || dot_zero_r) begin
          hit     = r2_r >= ac2_r;
          resolve = 1'b1;
        end else if (dot_mag_r >= ab2_r) begin
          op_nxt = OP_BC0;
        end else begin
          op_nxt = OP_T1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (resolve) begin
      if (hit) begin
        res_nxt   = '{segment_clear: 1'b0, first_hit_index: INDEX_BITS'(idx_r)};
        state_nxt = S_DONE;
      end else if (CW'(idx_r + 1'b1) == n_r) begin
        res_nxt   = '{segment_clear: 1'b1, first_hit_index: '0};
        state_nxt = S_DONE;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_FETCH;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_AB0;
      idx_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      pp_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      idx_r       <= idx_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      pp_v_r      <= state_r == S_MUL;
      if (cfg_valid) begin
        count_r <= cfg_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    pp_r     <= {{DIG_BITS{1'b0}}, x_dig} * {{DIG_BITS{1'b0}}, y_dig};
    pp_sh_r  <= (DIG_CNT_BITS+1)'(i_r) + (DIG_CNT_BITS+1)'(j_r);
    pp_neg_r <= op_neg;
    if (pp_v_r) begin
      acc_r <= pp_neg_r ? acc_r - sh_val : acc_r + sh_val;
    end else if (acc_clr) begin
      acc_r <= '0;
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r <= res_r;
    end
    if (q_pop && q_head.kind == KIND_QUERY) begin
      a_r[0] <= q_head.p0x;
      a_r[1] <= q_head.p0y;
      a_r[2] <= q_head.p0z;
      b_r[0] <= q_head.p1x;
      b_r[1] <= q_head.p1y;
      b_r[2] <= q_head.p1z;
    end
    if (state_r == S_QSTART) begin
      n_r <= (32'(count_r) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(count_r);
      for (int k = 0; k < 3; k++) begin
        {ab_neg_r[k], ab_mag_r[k]} <= diff_mag(b_r[k], a_r[k]);
      end
    end
    if (state_r == S_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        {ac_neg_r[k], ac_mag_r[k]} <= diff_mag(c_sel[k], a_r[k]);
        {bc_neg_r[k], bc_mag_r[k]} <= diff_mag(c_sel[k], b_r[k]);
      end
    end
    if (state_r == S_NEXT) begin
      case (op_r)
        OP_AB2: ab2_r <= acc_r[SQ_BITS-1:0];
        OP_AC2: ac2_r <= acc_r[SQ_BITS-1:0];
        OP_RR:  r2_r  <= acc_r[SQ_BITS-1:0];
        OP_DOT2: begin
          dot_neg_r  <= acc_r[ACC_BITS-1];
          dot_zero_r <= acc_r == '0;
          dot_mag_r  <= acc_abs[SQ_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // sphere table
  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == KIND_LOAD) begin
      mem[AIW'(q_head.slot)] <= '{x: q_head.p0x, y: q_head.p0y, z: q_head.p0z,
                                  r: q_head.radius};
    end
    if (state_r == S_FETCH) begin
      rd_r <= mem[idx_r[AIW-1:0]];
    end
  end

endmodule

// ===== design/segment_sphere_obstacle_check.sv =====
// Top level of the segment versus sphere-table obstacle check.
//
//   port group | direction | handshake          | payload
//   in_        | in        | in_valid / in_stall | sssc_in_t: load or query request
//   out_       | out       | out_valid/out_stall | sssc_out_t: clear flag, first hit
//   cfg_       | in        | cfg_valid/cfg_ready | sphere_count, 7 bits
//
// A load request is written into the sphere table as it leaves the queue.
// A query tests the entries in order until the first hit: each entry runs
// 7 to 10 passes through the one shared 32x32 multiply-accumulate.
// Front register and queue keep taking requests, until the queue is full, while the back end works or
// a result waits under out_stall. Reset is synchronous; the table is not cleared.
module segment_sphere_obstacle_check import sssc_pkg::*; #(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sssc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sssc_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_BITS-1:0] cfg_data
);

  sssc_push_t push;
  sssc_cmd_t  q_head;
  logic       q_full, q_empty, q_pop;

  sssc_front #(.MAX_SPHERES(MAX_SPHERES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .q_full   (q_full)
  );

  sssc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  sssc_back #(.MAX_SPHERES(MAX_SPHERES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/segment_sphere_obstacle_check_tb.sv =====
// Testbench for the segment/sphere obstacle check: random and directed requests, scoreboard.
module segment_sphere_obstacle_check_tb import sssc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT     = 64;
  localparam int CYC_LIMIT = 20000000;
  localparam int DRAIN_CYC = 80;

  typedef logic signed [127:0] prod_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  sssc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  sssc_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_BITS-1:0] cfg_data;

  segment_sphere_obstacle_check u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // shadow table and register
  longint    tbl_x [NSLOT];
  longint    tbl_y [NSLOT];
  longint    tbl_z [NSLOT];
  longint    tbl_r [NSLOT];
  int        tested_cnt;

  sssc_in_t  request_q [$];
  sssc_out_t verdict_q [$];

  int        n_sent;
  int        n_checked;
  int        n_hits;
  int        n_errors;
  int        n_cfg;
  int        cycles;

  function automatic longint sq3(longint dx, longint dy, longint dz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic bit sphere_touched(longint ax, longint ay, longint az,
                                        longint bx, longint by, longint bz, int idx);
    longint abx, aby, abz, acx, acy, acz;
    longint ab2, ac2, dotp, r2;
    prod_t  lhs, rhs;
    abx = bx - ax;
    aby = by - ay;
    abz = bz - az;
    acx = tbl_x[idx] - ax;
    acy = tbl_y[idx] - ay;
    acz = tbl_z[idx] - az;
    ab2 = sq3(abx, aby, abz);
    ac2 = sq3(acx, acy, acz);
    dotp = acx * abx + acy * aby + acz * abz;
    r2 = tbl_r[idx] * tbl_r[idx];
    if (dotp <= 0) return ac2 <= r2;
    if (dotp >= ab2) return sq3(tbl_x[idx] - bx, tbl_y[idx] - by, tbl_z[idx] - bz) <= r2;
    lhs = prod_t'(ac2) * prod_t'(ab2);
    rhs = prod_t'(dotp) * prod_t'(dotp) + prod_t'(r2) * prod_t'(ab2);
    return lhs <= rhs;
  endfunction

  function automatic void predict_request(sssc_in_t rq);
    sssc_out_t v;
    int        n;
    longint    ax, ay, az, bx, by, bz;
    if (kind_t'(rq.operation) == KIND_LOAD) begin
      tbl_x[rq.entry_index] = longint'($signed(rq.center_x));
      tbl_y[rq.entry_index] = longint'($signed(rq.center_y));
      tbl_z[rq.entry_index] = longint'($signed(rq.center_z));
      tbl_r[rq.entry_index] = longint'(rq.radius);
    end else begin
      ax = longint'($signed(rq.start_x));
      ay = longint'($signed(rq.start_y));
      az = longint'($signed(rq.start_z));
      bx = longint'($signed(rq.end_x));
      by = longint'($signed(rq.end_y));
      bz = longint'($signed(rq.end_z));
      n = (tested_cnt > NSLOT) ? NSLOT : tested_cnt;
      v.segment_clear = 1'b1;
      v.first_hit_index = '0;
      for (int i = 0; i < n; i++) begin
        if (sphere_touched(ax, ay, az, bx, by, bz, i)) begin
          v.segment_clear = 1'b0;
          v.first_hit_index = i[INDEX_BITS-1:0];
          break;
        end
      end
      verdict_q.push_back(v);
    end
  endfunction

  // driver: bursts with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(in_data);
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data  <= request_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  int pat_cnt;

  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 1;
    case (pat_cnt[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= $urandom_range(0, 1);
      2'd2: out_stall <= (pat_cnt[4:0] < 5'd22);
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    sssc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_errors < 10)
          $display("unexpected result clear=%0d idx=%0d",
                   out_data.segment_clear, out_data.first_hit_index);
      end else begin
        want = verdict_q.pop_front();
        n_checked <= n_checked + 1;
        if (!out_data.segment_clear) n_hits <= n_hits + 1;
        if (out_data.segment_clear !== want.segment_clear ||
            out_data.first_hit_index !== want.first_hit_index) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10)
            $display("mismatch #%0d: exp clear=%0d idx=%0d, got clear=%0d idx=%0d",
                     n_checked, want.segment_clear, want.first_hit_index,
                     out_data.segment_clear, out_data.first_hit_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic sssc_in_t any_request();
    logic [319:0] raw;
    sssc_in_t     rq;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    rq = raw[$bits(sssc_in_t)-1:0];
    return rq;
  endfunction

  function automatic sssc_in_t make_load(int slot, int cx, int cy, int cz, int r);
    sssc_in_t rq;
    rq = any_request();
    rq.operation   = KIND_LOAD;
    rq.entry_index = slot[INDEX_BITS-1:0];
    rq.center_x    = cx[COORD_BITS-1:0];
    rq.center_y    = cy[COORD_BITS-1:0];
    rq.center_z    = cz[COORD_BITS-1:0];
    rq.radius      = r[RADIUS_BITS-1:0];
    return rq;
  endfunction

  function automatic sssc_in_t make_query(int ax, int ay, int az, int bx, int by, int bz);
    sssc_in_t rq;
    rq = any_request();
    rq.operation = KIND_QUERY;
    rq.start_x   = ax[COORD_BITS-1:0];
    rq.start_y   = ay[COORD_BITS-1:0];
    rq.start_z   = az[COORD_BITS-1:0];
    rq.end_x     = bx[COORD_BITS-1:0];
    rq.end_y     = by[COORD_BITS-1:0];
    rq.end_z     = bz[COORD_BITS-1:0];
    return rq;
  endfunction

  function automatic int near_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic sssc_in_t random_request();
    sssc_in_t rq;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      rq = any_request();
    end else if (roll < 45) begin
      rq = make_load($urandom_range(0, NSLOT - 1), near_coord(2000), near_coord(2000),
                     near_coord(2000), $urandom_range(0, 400));
    end else begin
      rq = make_query(near_coord(3000), near_coord(3000), near_coord(3000),
                      near_coord(3000), near_coord(3000), near_coord(3000));
      if ($urandom_range(0, 9) == 0) begin
        rq.end_x = rq.start_x;
        rq.end_y = rq.start_y;
        rq.end_z = rq.start_z;
      end
    end
    return rq;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() > 0 || in_valid || verdict_q.size() > 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_count(int value);
    @(posedge clk);
    cfg_data  <= value[COUNT_BITS-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    tested_cnt = value;
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;

  int phase_cnt [12] = '{127, 0, 1, 64, 3, 8, 2, 5, 10, 64, 4, 6};

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    pat_cnt    = 0;
    tested_cnt = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_hits     = 0;
    n_errors   = 0;
    n_cfg      = 0;
    cycles     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    // with no entries tested every segment is clear
    request_q.push_back(make_query(CMIN, CMAX, 0, CMAX, CMIN, 0));
    request_q.push_back(make_load(0, CMAX, CMAX, CMAX, 0));
    request_q.push_back(make_load(1, CMIN, CMIN, CMIN, 0));
    request_q.push_back(make_load(2, 50, 30, 0, 30));
    request_q.push_back(make_load(3, 1000, 1000, 1000, 10));
    request_q.push_back(make_load(4, -500, 0, 0, 100));
    request_q.push_back(make_load(5, 0, 0, 0, CMAX));
    wait_idle();
    write_count(6);

    @(negedge clk);
    request_q.push_back(make_query(0, 0, 0, 100, 0, 0));            // touching
    request_q.push_back(make_query(1000, 1000, 990, 1000, 1000, 990)); // zero length
    request_q.push_back(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    request_q.push_back(make_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    request_q.push_back(make_query(-300, 0, 0, 200, 0, 0));         // behind start
    request_q.push_back(make_query(-900, 0, 0, -700, 0, 0));        // past end
    request_q.push_back(make_query(-700, 101, 0, -300, 101, 0));    // just clear
    request_q.push_back(make_query(5000, 5000, 5000, 6000, 6000, 6000));
    wait_idle();
    write_count(2);

    @(negedge clk);
    request_q.push_back(make_query(1000, 1000, 990, 1000, 1000, 990));
    request_q.push_back(make_query(50, 0, 0, 50, 0, 0));
    request_q.push_back(make_query(0, 61, 0, 100, 61, 0));
    wait_idle();

    @(negedge clk);
    for (int i = 0; i < NSLOT; i++)
      request_q.push_back(make_load(i, near_coord(2000), near_coord(2000),
                                    near_coord(2000), $urandom_range(0, 400)));
    wait_idle();

    foreach (phase_cnt[p]) begin
      write_count(phase_cnt[p]);
      @(negedge clk);
      for (int i = 0; i < 80; i++) request_q.push_back(random_request());
      wait_idle();
    end

    $display("%0d requests sent, %0d results checked (%0d blocked), %0d count settings",
             n_sent, n_checked, n_hits, n_cfg);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
